// File: hw/rtl/dsched_pkg.sv
// Shared types and constants for the disk request scheduler.
`default_nettype none
package dsched_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TRACK_BITS_DEF  = 16;
    localparam int KEY_W           = 32;
    localparam int ORDER_W         = 32;
    localparam int ID_W            = 16;

    localparam logic [2:0] MODE_FIFO  = 3'd0;
    localparam logic [2:0] MODE_SSTF  = 3'd1;
    localparam logic [2:0] MODE_LOOK  = 3'd2;
    localparam logic [2:0] MODE_CLOOK = 3'd3;
    localparam logic [2:0] MODE_FLOOK = 3'd4;

    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_GRANTED  = 2'd2;
    localparam logic [1:0] STAT_NONE     = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_PICK   = 1'b1;

    typedef struct packed {
        logic [2:0] mode;
        logic       dir_up;
        logic       active_batch;
    } eval_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_PICK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/dsched_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dsched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/dsched_eval.sv
// Per-slot class and key computation stage of the scan pipeline.
`default_nettype none
module dsched_eval
    import dsched_pkg::*;
#(
    parameter int TRACK_BITS = TRACK_BITS_DEF,
    parameter int IW         = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire eval_ctl_t             ctl,
    input  wire logic                  en,
    input  wire logic                  slot_vld,
    input  wire logic [IW-1:0]         idx,
    input  wire logic [ID_W-1:0]       slot_id,
    input  wire logic [TRACK_BITS-1:0] slot_track,
    input  wire logic [ORDER_W-1:0]    slot_order,
    input  wire logic                  slot_batch,
    input  wire logic [TRACK_BITS-1:0] head,
    input  wire logic [ORDER_W-1:0]    counter,
    output logic                       o_valid,
    output logic                       o_cls,
    output logic [KEY_W-1:0]           o_key,
    output logic [ID_W-1:0]            o_id,
    output logic [TRACK_BITS-1:0]      o_track,
    output logic                       o_batch,
    output logic [IW-1:0]              o_idx
);
    logic                  elig;
    logic                  ge;
    logic                  le;
    logic [TRACK_BITS-1:0] gap;
    logic                  cls;
    logic [KEY_W-1:0]      key;
    logic [ORDER_W-1:0]    age;

    always_comb
    begin
        elig = en && slot_vld && (ctl.mode != MODE_FLOOK || slot_batch == ctl.active_batch);
        ge   = slot_track >= head;
        le   = slot_track <= head;
        gap  = ge ? (slot_track - head) : (head - slot_track);
        age  = counter - slot_order;
        cls  = 1'b0;
        key  = KEY_W'(gap);
        case (ctl.mode)
            MODE_SSTF:
            begin
                cls = 1'b0;
            end
            MODE_LOOK, MODE_FLOOK:
            begin
                cls = ctl.dir_up ? !ge : !le;
            end
            MODE_CLOOK:
            begin
                cls = !ge;
                key = ge ? KEY_W'(gap) : KEY_W'(slot_track);
            end
            default:
            begin
                key = KEY_W'(~age);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid <= 1'b0;
        end
        else
        begin
            o_valid <= elig;
        end
    end

    always_ff @(posedge clk)
    begin
        o_cls   <= cls;
        o_key   <= key;
        o_id    <= slot_id;
        o_track <= slot_track;
        o_batch <= slot_batch;
        o_idx   <= idx;
    end
endmodule
`default_nettype wire

// File: hw/rtl/disk_request_scheduler_unit.sv
// Top level of the disk request scheduler: slot table, scan sequencer, output register.
// Each transfer either inserts a request into the lowest free slot or picks the next
// request under policy_mode. Both operations are served by one sequencer that steps
// through the slot table one slot per cycle: an insert stops at the first free slot
// (or reports full after the last slot), a pick always scans the whole table
// (through the registered RAM read and one key/compare stage).
// One item is in flight at a time; s_tready is high only while the sequencer is idle.
`default_nettype none
module disk_request_scheduler_unit
    import dsched_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TRACK_BITS  = TRACK_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_data,   // policy_mode
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,       // request_id, request_track, head_position
    input  wire logic [0:0]  s_tuser,       // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,       // granted_id, granted_track, sweep_up, pad
    output logic [1:0]       m_tuser        // status
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = 1 + ORDER_W + TRACK_BITS + ID_W;

    state_t state_reg, state_next;

    logic [2:0]             mode_reg;
    logic [2:0]             mode;
    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [CW-1:0]          cnt_reg [2];
    logic [ORDER_W-1:0]     counter_reg;
    logic                   ab_reg;
    logic                   dir_reg;
    logic [CW-1:0]          c_reg;
    logic                   p1_reg;
    logic                   p2_reg;
    logic [IW-1:0]          p1_idx_reg;

    logic                   op_reg;
    logic [ID_W-1:0]        id_reg;
    logic [TRACK_BITS-1:0]  trk_reg;
    logic [TRACK_BITS-1:0]  head_reg;

    logic                   found_reg;
    logic                   bcls_reg;
    logic [KEY_W-1:0]       bkey_reg;
    logic [ID_W-1:0]        bid_reg;
    logic [TRACK_BITS-1:0]  btrk_reg;
    logic                   bbatch_reg;
    logic [IW-1:0]          bidx_reg;

    logic [1:0]             res_stat_reg;
    logic [ID_W-1:0]        res_id_reg;
    logic [15:0]            res_trk_reg;

    logic                   out_valid_reg;
    logic [1:0]             out_stat_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic [15:0]            out_trk_reg;
    logic                   out_sweep_reg;

    logic                   in_xfer;
    logic                   issue;
    logic [IW-1:0]          scan_idx;
    logic                   ins_full;
    logic                   ins_hit;
    logic                   pick_end;
    logic                   ins_batch;
    logic                   ram_we;
    logic [RW-1:0]          ram_wdata;
    logic [RW-1:0]          ram_rdata;
    eval_ctl_t              ectl;

    logic                   e_valid;
    logic                   e_cls;
    logic [KEY_W-1:0]       e_key;
    logic [ID_W-1:0]        e_id;
    logic [TRACK_BITS-1:0]  e_track;
    logic                   e_batch;
    logic [IW-1:0]          e_idx;
    logic                   better;

    assign mode      = (mode_reg <= MODE_FLOOK) ? mode_reg : MODE_FIFO;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign scan_idx  = c_reg[IW-1:0];
    assign issue     = (state_reg == S_PICK) && (c_reg < CW'(QUEUE_DEPTH));
    assign ins_full  = (state_reg == S_INS) && (c_reg == CW'(QUEUE_DEPTH));
    assign ins_hit   = (state_reg == S_INS) && !ins_full && !valid_reg[scan_idx];
    assign pick_end  = (state_reg == S_PICK) && (c_reg == CW'(QUEUE_DEPTH)) && !p1_reg && !p2_reg;
    assign ins_batch = (mode == MODE_FLOOK) ? !ab_reg : ab_reg;
    assign ram_we    = ins_hit;
    assign ram_wdata = {ins_batch, counter_reg, trk_reg, id_reg};
    assign ectl      = '{mode: mode, dir_up: dir_reg, active_batch: ab_reg};

    assign better = !found_reg || (e_cls < bcls_reg) ||
                    (e_cls == bcls_reg && (e_key < bkey_reg ||
                    (e_key == bkey_reg && e_id < bid_reg)));

    dsched_ram #(
        .WIDTH(RW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(scan_idx),
        .wr_data(ram_wdata),
        .rd_addr(scan_idx),
        .rd_data(ram_rdata)
    );

    dsched_eval #(
        .TRACK_BITS(TRACK_BITS),
        .IW        (IW)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ectl),
        .en        (p1_reg),
        .slot_vld  (valid_reg[p1_idx_reg]),
        .idx       (p1_idx_reg),
        .slot_id   (ram_rdata[ID_W-1:0]),
        .slot_track(ram_rdata[ID_W +: TRACK_BITS]),
        .slot_order(ram_rdata[ID_W+TRACK_BITS +: ORDER_W]),
        .slot_batch(ram_rdata[RW-1]),
        .head      (head_reg),
        .counter   (counter_reg),
        .o_valid   (e_valid),
        .o_cls     (e_cls),
        .o_key     (e_key),
        .o_id      (e_id),
        .o_track   (e_track),
        .o_batch   (e_batch),
        .o_idx     (e_idx)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (s_tuser[0] == OP_PICK) ? S_PICK : S_INS;
                end
            end
            S_INS:
            begin
                if (ins_full || ins_hit)
                begin
                    state_next = S_DONE;
                end
            end
            S_PICK:
            begin
                if (pick_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_FIFO;
            valid_reg     <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            counter_reg   <= '0;
            ab_reg        <= 1'b0;
            dir_reg       <= 1'b1;
            c_reg         <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p1_reg    <= issue;
            p2_reg    <= p1_reg;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (in_xfer)
            begin
                c_reg     <= '0;
                found_reg <= 1'b0;
                if (s_tuser[0] == OP_PICK && mode == MODE_FLOOK &&
                    cnt_reg[ab_reg] == '0 && cnt_reg[!ab_reg] != '0)
                begin
                    ab_reg <= !ab_reg;
                end
            end
            if ((state_reg == S_INS && !ins_full && !ins_hit) || issue)
            begin
                c_reg <= c_reg + 1'b1;
            end
            if (ins_hit)
            begin
                valid_reg[scan_idx] <= 1'b1;
                cnt_reg[ins_batch]  <= cnt_reg[ins_batch] + 1'b1;
                counter_reg         <= counter_reg + 1'b1;
            end
            if (e_valid && better)
            begin
                found_reg <= 1'b1;
            end
            if (pick_end && found_reg)
            begin
                valid_reg[bidx_reg] <= 1'b0;
                cnt_reg[bbatch_reg] <= cnt_reg[bbatch_reg] - 1'b1;
                if (btrk_reg > head_reg)
                begin
                    dir_reg <= 1'b1;
                end
                else if (btrk_reg < head_reg)
                begin
                    dir_reg <= 1'b0;
                end
            end
            if (state_reg == S_DONE && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= s_tuser[0];
            id_reg   <= s_tdata[15:0];
            trk_reg  <= TRACK_BITS'(s_tdata[31:16]);
            head_reg <= TRACK_BITS'(s_tdata[47:32]);
        end
        if (issue)
        begin
            p1_idx_reg <= scan_idx;
        end
        if (e_valid && better)
        begin
            bcls_reg   <= e_cls;
            bkey_reg   <= e_key;
            bid_reg    <= e_id;
            btrk_reg   <= e_track;
            bbatch_reg <= e_batch;
            bidx_reg   <= e_idx;
        end
        if (ins_full || ins_hit)
        begin
            res_stat_reg <= ins_hit ? STAT_INSERTED : STAT_FULL;
            res_id_reg   <= '0;
            res_trk_reg  <= '0;
        end
        if (pick_end)
        begin
            res_stat_reg <= found_reg ? STAT_GRANTED : STAT_NONE;
            res_id_reg   <= found_reg ? bid_reg : '0;
            res_trk_reg  <= found_reg ? 16'(btrk_reg) : '0;
        end
        if (state_reg == S_DONE && (!out_valid_reg || m_tready))
        begin
            out_stat_reg  <= res_stat_reg;
            out_id_reg    <= res_id_reg;
            out_trk_reg   <= res_trk_reg;
            out_sweep_reg <= dir_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {7'd0, out_sweep_reg, out_trk_reg, out_id_reg};

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cnt_reg[0]) + 32'(cnt_reg[1])) <= 32'(QUEUE_DEPTH))
        else $error("batch counts exceed table depth");

    a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (32'(cnt_reg[0]) + 32'(cnt_reg[1])) == 32'($countones(valid_reg)))
        else $error("batch counts disagree with valid bits");

    a_zero_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STAT_GRANTED) |-> (m_tdata[31:0] == 32'd0))
        else $error("non-grant result carries id or track");

    a_insert_op: assert property (@(posedge clk) disable iff (!rst_n)
        ins_hit |-> (op_reg == OP_INSERT))
        else $error("slot written during pick");

    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        pick_end |-> !issue && !e_valid)
        else $error("pick finished with scan in flight");
endmodule
`default_nettype wire

// File: bench/tb_disk_request_scheduler_unit.sv
// Self-checking testbench for the disk request scheduler: directed table plus random traffic.
module tb_disk_request_scheduler_unit
    import dsched_pkg::*;
();

    localparam int DEPTH = 64;

    typedef struct packed {
        logic        op;
        logic [15:0] id;
        logic [15:0] track;
        logic [15:0] head;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] gid;
        logic [15:0] gtrack;
        logic        sweep;
    } grant_t;

    typedef struct {
        req_t   rq;
        logic   chk;
        grant_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    disk_request_scheduler_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // scheduler shadow state
    logic [2:0]  sh_mode;
    logic        sh_valid [DEPTH];
    logic [15:0] sh_id    [DEPTH];
    logic [15:0] sh_track [DEPTH];
    logic [31:0] sh_stamp [DEPTH];
    logic        sh_batch [DEPTH];
    logic [31:0] sh_count;
    logic        sh_active;
    logic        sh_up;

    grant_t pending_grants[$];
    int     errors;
    int     send_idle_pct;
    int     recv_idle_pct;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic batch_nonempty(logic b);
        for (int i = 0; i < DEPTH; i++)
            if (sh_valid[i] && sh_batch[i] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic grant_t schedule_step(req_t rq);
        grant_t g;
        logic [2:0] md;
        int best;
        int cls, bcls;
        logic [32:0] key, bkey;
        logic [15:0] bid;
        logic [16:0] t, h, gap;
        md = (sh_mode <= MODE_FLOOK) ? sh_mode : MODE_FIFO;
        g = '0;
        best = -1;
        bcls = 0;
        bkey = '0;
        bid = '0;
        if (rq.op == OP_INSERT)
        begin
            for (int i = 0; i < DEPTH; i++)
                if (!sh_valid[i] && best < 0)
                    best = i;
            if (best < 0)
                g.status = STAT_FULL;
            else
            begin
                sh_valid[best] = 1'b1;
                sh_id[best] = rq.id;
                sh_track[best] = rq.track;
                sh_stamp[best] = sh_count;
                sh_batch[best] = (md == MODE_FLOOK) ? ~sh_active : sh_active;
                sh_count = sh_count + 1;
                g.status = STAT_INSERTED;
            end
        end
        else
        begin
            h = {1'b0, rq.head};
            if (md == MODE_FLOOK && !batch_nonempty(sh_active) && batch_nonempty(~sh_active))
                sh_active = ~sh_active;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (sh_valid[i] && !(md == MODE_FLOOK && sh_batch[i] != sh_active))
                begin
                    t = {1'b0, sh_track[i]};
                    gap = (t >= h) ? t - h : h - t;
                    cls = 0;
                    if (md == MODE_SSTF)
                        key = {16'b0, gap};
                    else if (md == MODE_LOOK || md == MODE_FLOOK)
                    begin
                        cls = (sh_up ? (t >= h) : (t <= h)) ? 0 : 1;
                        key = {16'b0, gap};
                    end
                    else if (md == MODE_CLOOK)
                    begin
                        cls = (t >= h) ? 0 : 1;
                        key = cls ? {16'b0, t} : {16'b0, gap};
                    end
                    else
                        key = {1'b0, 32'hFFFF_FFFF - (sh_count - sh_stamp[i])};
                    if (best < 0 || cls < bcls ||
                        (cls == bcls && (key < bkey || (key == bkey && sh_id[i] < bid))))
                    begin
                        best = i;
                        bcls = cls;
                        bkey = key;
                        bid = sh_id[i];
                    end
                end
            end
            if (best < 0)
                g.status = STAT_NONE;
            else
            begin
                g.status = STAT_GRANTED;
                g.gid = sh_id[best];
                g.gtrack = sh_track[best];
                sh_valid[best] = 1'b0;
                if (sh_track[best] > rq.head)
                    sh_up = 1'b1;
                else if (sh_track[best] < rq.head)
                    sh_up = 1'b0;
            end
        end
        g.sweep = sh_up;
        return g;
    endfunction

    task automatic write_mode(logic [2:0] m);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sh_mode = m;
    endtask

    task automatic drain();
        while (pending_grants.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // drives one transfer; fixed expectation used when chk is set
    task automatic send_req(req_t rq, logic chk, grant_t want);
        grant_t g;
        @(negedge clk);
        while (($urandom_range(99) < send_idle_pct))
            @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {rq.head, rq.track, rq.id};
        s_tuser <= rq.op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        g = schedule_step(rq);
        if (chk && g !== want)
        begin
            $display("%0t directed row: expected %h actual predictor %h", $time, want, g);
            errors++;
        end
        pending_grants.insert(pending_grants.size(), g);
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    function automatic req_t rand_req(int pick_pct, int tmax);
        req_t rq;
        rq.op = ($urandom_range(99) < pick_pct) ? OP_PICK : OP_INSERT;
        rq.id = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'($urandom);
        rq.track = 16'($urandom_range(tmax));
        rq.head = 16'($urandom_range(tmax));
        if ($urandom_range(9) == 0)
            rq.track = 16'hFFFF;
        return rq;
    endfunction

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        grant_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[32]};
            if (pending_grants.size() == 0)
            begin
                $display("%0t unexpected transfer: expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (got.status !== want.status || got.gid !== want.gid ||
                    got.gtrack !== want.gtrack || got.sweep !== want.sweep)
                begin
                    $display("%0t mismatch: expected st=%0d id=%h tr=%h up=%b actual st=%0d id=%h tr=%h up=%b",
                        $time, want.status, want.gid, want.gtrack, want.sweep,
                        got.status, got.gid, got.gtrack, got.sweep);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        row_t rows[$];
        row_t r;
        grant_t none_g;
        logic [2:0] modes[8];
        int seg;
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        sh_mode = MODE_FIFO;
        for (int i = 0; i < DEPTH; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_id[i] = '0;
            sh_track[i] = '0;
            sh_stamp[i] = '0;
            sh_batch[i] = 1'b0;
        end
        sh_count = '0;
        sh_active = 1'b0;
        sh_up = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fifo after reset
        none_g = '{status: STAT_NONE, gid: 16'h0, gtrack: 16'h0, sweep: 1'b1};
        r.chk = 1'b1;
        r.rq = '{OP_PICK, 16'hFFFF, 16'hFFFF, 16'h1234};
        r.want = none_g;
        rows.insert(rows.size(), r);
        r.rq = '{OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        r.want = '{STAT_INSERTED, 16'h0, 16'h0, 1'b1};
        rows.insert(rows.size(), r);
        r.rq = '{OP_INSERT, 16'h0000, 16'h0000, 16'h0};
        r.want = '{STAT_INSERTED, 16'h0, 16'h0, 1'b1};
        rows.insert(rows.size(), r);
        r.rq = '{OP_PICK, 16'h0, 16'h0, 16'h0000};
        r.want = '{STAT_GRANTED, 16'hFFFF, 16'hFFFF, 1'b1};
        rows.insert(rows.size(), r);
        r.rq = '{OP_PICK, 16'h0, 16'h0, 16'hFFFF};
        r.want = '{STAT_GRANTED, 16'h0000, 16'h0000, 1'b0};
        rows.insert(rows.size(), r);
        r.rq = '{OP_PICK, 16'h0, 16'h0, 16'h0};
        r.want = '{STAT_NONE, 16'h0, 16'h0, 1'b0};
        rows.insert(rows.size(), r);
        foreach (rows[i])
            send_req(rows[i].rq, rows[i].chk, rows[i].want);
        drain();

        // each scan policy (SSTF, LOOK, C-LOOK, F-LOOK) over a small set incl. ties and head-equal tracks
        modes = '{MODE_SSTF, MODE_LOOK, MODE_CLOOK, MODE_FLOOK, 3'd5, 3'd6, 3'd7, MODE_FIFO};
        for (int m = 0; m < 4; m++)
        begin
            write_mode(modes[m]);
            rows.delete();
            r.chk = 1'b0;
            r.want = '0;
            r.rq = '{OP_INSERT, 16'd9, 16'd100, 16'd0};  rows.insert(rows.size(), r);
            r.rq = '{OP_INSERT, 16'd3, 16'd300, 16'd0};  rows.insert(rows.size(), r);
            r.rq = '{OP_INSERT, 16'd5, 16'd100, 16'd0};  rows.insert(rows.size(), r);
            r.rq = '{OP_INSERT, 16'd1, 16'd200, 16'd0};  rows.insert(rows.size(), r);
            r.rq = '{OP_PICK, 16'd0, 16'd0, 16'd200};    rows.insert(rows.size(), r);
            r.rq = '{OP_PICK, 16'd0, 16'd0, 16'd200};    rows.insert(rows.size(), r);
            r.rq = '{OP_PICK, 16'd0, 16'd0, 16'd100};    rows.insert(rows.size(), r);
            r.rq = '{OP_INSERT, 16'd2, 16'd50, 16'd0};   rows.insert(rows.size(), r);
            r.rq = '{OP_PICK, 16'd0, 16'd0, 16'd250};    rows.insert(rows.size(), r);
            r.rq = '{OP_PICK, 16'd0, 16'd0, 16'd250};    rows.insert(rows.size(), r);
            foreach (rows[i])
                send_req(rows[i].rq, 1'b0, none_g);
            drain();
            while (batch_nonempty(1'b0) || batch_nonempty(1'b1))
                send_req('{OP_PICK, 16'd0, 16'd0, 16'd0}, 1'b0, none_g);
            drain();
        end

        // random phases; table fill pushes some to full
        for (int n = 0; n < 1300; n++)
        begin
            seg = n / 100;
            if (n % 100 == 0)
            begin
                drain();
                write_mode(modes[seg % 8]);
            end
            if (n < 430)
            begin
                send_idle_pct = 13;
                recv_idle_pct = 48;
            end
            else if (n < 860)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 13;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == 650)
                drain();
            send_req(rand_req((seg % 3 == 1) ? 20 : 50, (seg % 2) ? 255 : 65535),
                     1'b0, none_g);
        end
        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
